/* design/canonical_kmer_table_lookup_macros.svh */
// ----------------------------------------------------------------------------
// Canonical k-mer table lookup: assertion macros
// Shared clocked assertion forms with the reset disable.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_KMER_TABLE_LOOKUP_MACROS_SVH
`define CANONICAL_KMER_TABLE_LOOKUP_MACROS_SVH

// same-cycle implication
`define CKMER_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ckmer assertion failed");

// next-cycle implication
`define CKMER_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ckmer assertion failed");

`endif

/* design/ckmer_pkg.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer table lookup: package
// Table geometry, opcodes, register map and reverse-complement helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ckmer_pkg;

	localparam int TABLE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KMER_W      = 62;
	localparam int BASES       = KMER_W / 2;
	localparam int LEN_W       = 5;
	localparam int ENTRY_W     = 64;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_W   = PADDR_W - 2;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(31);

	localparam logic [REG_IDX_W-1:0] REG_KMER_LENGTH = '0;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// reverse complement over len bases (complement of a 2-bit base is its inverse)
	function automatic logic [KMER_W-1:0] revcomp(input logic [KMER_W-1:0] v,
			input logic [LEN_W-1:0] len);
		logic [KMER_W-1:0] full;
		logic [LEN_W-1:0]  drop;
		logic [LEN_W:0]    shamt;
		full = '0;
		for (int i = 0; i < BASES; i++) begin
			full[2*(BASES-1-i) +: 2] = ~v[2*i +: 2];
		end
		drop  = LEN_W'(BASES) - len;
		shamt = {drop, 1'b0};
		return full >> shamt;
	endfunction

endpackage

`default_nettype wire

/* design/ckmer_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ckmer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/canonical_kmer_table_lookup.sv */
// Sequence: clear and load act on their transfer; a query goes RCOMP, CANON, then
// at most ceil(log2(entry_count + 1)) halvings, each a SEARCH (RAM read) and a COMPARE,
// then MATCH (skipped if the search ends past the last entry), DONE and out_valid.
// Throughput: one clear/load transfer per cycle while idle, one query at a time otherwise.
// Reset: arst_n clears the sequencer, entry count and output valid; kmer_length = 31.
// Table contents are not reset; only entries below the entry count are used.
// ----------------------------------------------------------------------------
// Canonical k-mer table lookup
// Canonizes a query k-mer and binary-searches a loaded, sorted k-mer table.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_kmer_table_lookup (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [1:0]                         opcode,
	input  wire  [ckmer_pkg::ENTRY_W-1:0]      entry_word,
	input  wire  [ckmer_pkg::KMER_W-1:0]       query_kmer,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic                               found,
	output logic [ckmer_pkg::KMER_W-1:0]       canonical_kmer,
	output logic                               reverse_taken,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [ckmer_pkg::PADDR_W-1:0]      paddr,
	input  wire  [ckmer_pkg::PDATA_W-1:0]      pwdata,
	output logic [ckmer_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_RCOMP   = 7'b0000010,
		ST_CANON   = 7'b0000100,
		ST_SEARCH  = 7'b0001000,
		ST_COMPARE = 7'b0010000,
		ST_MATCH   = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

	state_t                           state_q;
	logic [ckmer_pkg::LEN_W-1:0]      kmer_length_q;
	logic [ckmer_pkg::CNT_W-1:0]      entry_count_q;
	logic [ckmer_pkg::KMER_W-1:0]     query_q;
	logic [ckmer_pkg::KMER_W-1:0]     rc_q;
	logic [ckmer_pkg::KMER_W-1:0]     key_q;
	logic                             rev_q;
	logic                             found_q;
	logic [ckmer_pkg::CNT_W-1:0]      first_q;
	logic [ckmer_pkg::CNT_W-1:0]      count_q;
	logic [ckmer_pkg::CNT_W-1:0]      probe_q;
	logic [ckmer_pkg::CNT_W-1:0]      step_q;

	logic                             in_xfer;
	logic                             cfg_wr;
	logic [ckmer_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                             tbl_we;
	logic                             tbl_re;
	logic [ckmer_pkg::ADDR_W-1:0]     tbl_raddr;
	logic [ckmer_pkg::KMER_W-1:0]     tbl_rdata;
	logic [ckmer_pkg::CNT_W-1:0]      step;
	logic [ckmer_pkg::CNT_W-1:0]      probe;
	logic                             out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ckmer_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (reg_idx == ckmer_pkg::REG_KMER_LENGTH) begin
			prdata = ckmer_pkg::PDATA_W'(kmer_length_q);
		end
	end

	// table
	assign tbl_we = in_xfer && (opcode == ckmer_pkg::OP_LOAD)
		&& (entry_count_q < ckmer_pkg::CNT_W'(ckmer_pkg::TABLE_DEPTH));

	assign step  = count_q >> 1;
	assign probe = first_q + step;

	always_comb begin
		tbl_re    = 1'b0;
		tbl_raddr = first_q[ckmer_pkg::ADDR_W-1:0];
		if (state_q == ST_SEARCH) begin
			tbl_re = 1'b1;
			if (count_q != '0) begin
				tbl_raddr = probe[ckmer_pkg::ADDR_W-1:0];
			end
		end
	end

	ckmer_ram #(
		.WIDTH(ckmer_pkg::KMER_W),
		.DEPTH(ckmer_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_count_q[ckmer_pkg::ADDR_W-1:0]),
		.wdata (entry_word[ckmer_pkg::KMER_W-1:0]),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= ckmer_pkg::LEN_RESET;
		end else if (cfg_wr && reg_idx == ckmer_pkg::REG_KMER_LENGTH) begin
			kmer_length_q <= pwdata[ckmer_pkg::LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (in_xfer && opcode == ckmer_pkg::OP_CLEAR) begin
			entry_count_q <= '0;
		end else if (tbl_we) begin
			entry_count_q <= entry_count_q + 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && opcode == ckmer_pkg::OP_QUERY) begin
						state_q <= ST_RCOMP;
					end
				end
				ST_RCOMP:   state_q <= ST_CANON;
				ST_CANON:   state_q <= ST_SEARCH;
				ST_SEARCH: begin
					if (count_q != '0) begin
						state_q <= ST_COMPARE;
					end else if (first_q < entry_count_q) begin
						state_q <= ST_MATCH;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_COMPARE: state_q <= ST_SEARCH;
				ST_MATCH:   state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					query_q <= query_kmer;
				end
			end
			ST_RCOMP: begin
				rc_q <= ckmer_pkg::revcomp(query_q, kmer_length_q);
			end
			ST_CANON: begin
				if (query_q < rc_q) begin
					key_q <= query_q;
					rev_q <= 1'b0;
				end else begin
					key_q <= rc_q;
					rev_q <= 1'b1;
				end
				first_q <= '0;
				count_q <= entry_count_q;
				found_q <= 1'b0;
			end
			ST_SEARCH: begin
				probe_q <= probe;
				step_q  <= step;
			end
			ST_COMPARE: begin
				if (tbl_rdata < key_q) begin
					first_q <= probe_q + 1'b1;
					count_q <= count_q - step_q - 1'b1;
				end else begin
					count_q <= step_q;
				end
			end
			ST_MATCH: begin
				found_q <= (tbl_rdata == key_q);
			end
			ST_DONE: begin
				if (out_free) begin
					found          <= found_q;
					canonical_kmer <= key_q;
					reverse_taken  <= rev_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/ckmer_checker.sv */
// ----------------------------------------------------------------------------
// Canonical k-mer table lookup: port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "canonical_kmer_table_lookup_macros.svh"

module ckmer_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_stall,
	input wire [1:0]                      opcode,
	input wire                            out_valid,
	input wire                            out_stall,
	input wire                            found,
	input wire [ckmer_pkg::KMER_W-1:0]    canonical_kmer,
	input wire                            reverse_taken,
	input wire                            pready
);

	logic in_xfer;
	logic is_query;

	assign in_xfer  = in_valid && !in_stall;
	assign is_query = (opcode == ckmer_pkg::OP_QUERY);

	`CKMER_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(found) && $stable(canonical_kmer) && $stable(reverse_taken))

	`CKMER_ASSERT_NEXT(a_query_busy, in_xfer && is_query, in_stall)

	`CKMER_ASSERT_NEXT(a_ctrl_one_cycle, in_xfer && !is_query, !in_stall)

	`CKMER_ASSERT_NEXT(a_no_early_result, in_xfer && (!out_valid || !out_stall), !out_valid)

	`CKMER_ASSERT_NOW(a_pready_high, arst_n, pready)

endmodule

bind canonical_kmer_table_lookup ckmer_checker u_ckmer_checker (.*);

`default_nettype wire
